// ===== src/bmi_pkg.sv =====
// bmi_pkg: shared types and constants of the binary mlp inference unit
// word layouts, command codes and layer sizes; no dependencies
package bmi_pkg;

  localparam int IN_COUNT     = 16;
  localparam int HIDDEN_COUNT = 32;
  localparam int OUT_COUNT    = 8;

  localparam int CMD_W  = 2;
  localparam int IDX_W  = 5;
  localparam int WORD_W = 32;
  localparam int ACT_W  = 16;
  localparam int HID_W  = 32;
  localparam int OBIT_W = 8;

  localparam int IDX_EXT_W  = IDX_W + 1;
  localparam int HID_IDX_W  = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int OUT_IDX_W  = (OUT_COUNT > 1) ? $clog2(OUT_COUNT) : 1;
  localparam int IN_CNT_W   = $clog2(IN_COUNT + 1);
  localparam int HID_CNT_W  = $clog2(HIDDEN_COUNT + 1);
  localparam int IN_HALF    = (IN_COUNT + 1) / 2;
  localparam int HID_HALF   = (HIDDEN_COUNT + 1) / 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_HIDDEN = 2'd0,
    CMD_LOAD_OUTPUT = 2'd1,
    CMD_INFER       = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [IDX_W-1:0]  neuron_index;
    logic [WORD_W-1:0] weight_word;
    logic [ACT_W-1:0]  activations;
  } in_word_t;

  typedef struct packed {
    logic [HID_W-1:0]  hidden_bits;
    logic [OBIT_W-1:0] out_bits;
  } out_word_t;

endpackage

// ===== src/bmi_hidden_lane.sv =====
// bmi_hidden_lane: one hidden neuron, xnor popcount against its weight column
// depends on bmi_pkg
module bmi_hidden_lane import bmi_pkg::*; (
  input  logic [IN_COUNT-1:0] act,
  input  logic [IN_COUNT-1:0] weights,
  output logic                fires
);

  logic [IN_COUNT-1:0]  agree_vec;
  logic [IN_CNT_W-1:0]  agree_cnt;

  always_comb begin
    agree_vec = ~(act ^ weights);
    agree_cnt = '0;
    for (int i = 0; i < IN_COUNT; i++) begin
      agree_cnt = agree_cnt + IN_CNT_W'(agree_vec[i]);
    end
    fires = (agree_cnt >= IN_CNT_W'(IN_HALF));
  end

endmodule

// ===== src/bmi_output_lane.sv =====
// bmi_output_lane: one output neuron, xnor popcount over the hidden signs
// depends on bmi_pkg
module bmi_output_lane import bmi_pkg::*; (
  input  logic [HIDDEN_COUNT-1:0] hid,
  input  logic [HIDDEN_COUNT-1:0] weights,
  output logic                    fires
);

  logic [HIDDEN_COUNT-1:0] agree_vec;
  logic [HID_CNT_W-1:0]    agree_cnt;

  always_comb begin
    agree_vec = ~(hid ^ weights);
    agree_cnt = '0;
    for (int i = 0; i < HIDDEN_COUNT; i++) begin
      agree_cnt = agree_cnt + HID_CNT_W'(agree_vec[i]);
    end
    fires = (agree_cnt >= HID_CNT_W'(HID_HALF));
  end

endmodule

// ===== src/binary_mlp_inference_unit.sv =====
// binary_mlp_inference_unit: two-layer binarized perceptron, top level
// depends on bmi_pkg, bmi_hidden_lane, bmi_output_lane
// pipeline: two register stages; an infer word goes through stage one, then the output register
// throughput: one word per cycle unless out_stall holds the pipe; hidden lanes run in the accept
// cycle, output lanes in the second stage, each stage ended by a register
// reset clears the stage and output valid flags; weight columns are not cleared
module binary_mlp_inference_unit import bmi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic [IN_COUNT-1:0]     hid_w_r [HIDDEN_COUNT];
  logic [HIDDEN_COUNT-1:0] out_w_r [OUT_COUNT];

  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_infer_r;
  logic [OUT_IDX_W-1:0]    s1_idx_r;
  logic [HIDDEN_COUNT-1:0] s1_word_r;
  logic [HIDDEN_COUNT-1:0] s1_hid_r;

  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r;

  logic                    in_acc, adv_out;
  logic                    is_infer, is_load_hid, is_load_out, s1_take;
  logic [IDX_EXT_W-1:0]    idx_ext;
  logic [IN_COUNT-1:0]     act;
  logic [HIDDEN_COUNT-1:0] hid_now;
  logic [OUT_COUNT-1:0]    obits_now;
  logic [HID_W-1:0]        hid_fit;
  logic [OBIT_W-1:0]       obits_fit;

  assign adv_out  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv_out;
  assign in_acc   = in_valid && !in_stall;

  assign idx_ext     = {1'b0, in_data.neuron_index};
  assign is_infer    = (in_data.cmd == CMD_INFER);
  assign is_load_hid = (in_data.cmd == CMD_LOAD_HIDDEN) &&
                       (idx_ext < IDX_EXT_W'(HIDDEN_COUNT));
  assign is_load_out = (in_data.cmd == CMD_LOAD_OUTPUT) &&
                       (idx_ext < IDX_EXT_W'(OUT_COUNT));
  assign s1_take     = in_acc && (is_infer || is_load_out);

  assign act = IN_COUNT'(in_data.activations);

  // hidden layer lanes
  for (genvar j = 0; j < HIDDEN_COUNT; j++) begin : g_hid
    bmi_hidden_lane u_lane (
      .act     (act),
      .weights (hid_w_r[j]),
      .fires   (hid_now[j])
    );
  end

  // output layer lanes
  for (genvar k = 0; k < OUT_COUNT; k++) begin : g_out
    bmi_output_lane u_lane (
      .hid     (s1_hid_r),
      .weights (out_w_r[k]),
      .fires   (obits_now[k])
    );
  end

  assign hid_fit   = HID_W'(s1_hid_r);
  assign obits_fit = OBIT_W'(obits_now);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (adv_out) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_take) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (adv_out) begin
      out_valid_nxt = s1_valid_r && s1_infer_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hidden columns are written at accept, ahead of any later infer
  always_ff @(posedge clk) begin
    if (in_acc && is_load_hid) begin
      hid_w_r[in_data.neuron_index[HID_IDX_W-1:0]] <= IN_COUNT'(in_data.weight_word);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_infer_r <= is_infer;
      s1_idx_r   <= in_data.neuron_index[OUT_IDX_W-1:0];
      s1_word_r  <= HIDDEN_COUNT'(in_data.weight_word);
      s1_hid_r   <= hid_now;
    end
  end

  // output columns are written as the load leaves stage one, keeping word order
  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r && !s1_infer_r) begin
      out_w_r[s1_idx_r] <= s1_word_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r && s1_infer_r) begin
      out_data_r.hidden_bits <= hid_fit;
      out_data_r.out_bits    <= obits_fit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== verif/tb_binary_mlp_inference_unit.sv =====
// tb_binary_mlp_inference_unit: self-checking bench for the binarized two-layer perceptron
// drives load and infer words from a directed table, then at random; checks every result
// word with its table value or a built-in xnor/popcount predictor; depends on bmi_pkg, rtl
module tb_binary_mlp_inference_unit;
  import bmi_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_WORDS = 990;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t exp;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  bit        row_typed;
  out_word_t row_expect;

  logic [IN_COUNT-1:0]     hidden_cols [HIDDEN_COUNT];
  logic [HIDDEN_COUNT-1:0] output_cols [OUT_COUNT];
  out_word_t               inference_q [$];

  int  error_count;
  int  cycle_count;
  bit  in_steady;
  bit  out_steady;

  binary_mlp_inference_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_word_t infer_layers(logic [ACT_W-1:0] act);
    out_word_t               r;
    logic [HIDDEN_COUNT-1:0] hid;
    int                      agree;
    r   = '0;
    hid = '0;
    for (int j = 0; j < HIDDEN_COUNT; j++) begin
      agree  = $countones(~(act[IN_COUNT-1:0] ^ hidden_cols[j]));
      hid[j] = (2 * agree >= IN_COUNT);
    end
    for (int k = 0; k < OUT_COUNT; k++) begin
      agree         = $countones(~(hid ^ output_cols[k]));
      r.out_bits[k] = (2 * agree >= HIDDEN_COUNT);
    end
    r.hidden_bits = hid;
    return r;
  endfunction

  task automatic store_column(input in_word_t w);
    if (w.cmd == CMD_LOAD_HIDDEN && w.neuron_index < HIDDEN_COUNT) begin
      hidden_cols[w.neuron_index[HID_IDX_W-1:0]] = w.weight_word[IN_COUNT-1:0];
    end else if (w.cmd == CMD_LOAD_OUTPUT && w.neuron_index < OUT_COUNT) begin
      output_cols[w.neuron_index[OUT_IDX_W-1:0]] = w.weight_word[HIDDEN_COUNT-1:0];
    end
  endtask

  function automatic stim_row_t mk_row(logic [CMD_W-1:0] cmd, int idx, logic [WORD_W-1:0] word,
                                       logic [ACT_W-1:0] act, int typed,
                                       logic [HID_W-1:0] hid, logic [OBIT_W-1:0] ob);
    stim_row_t r;
    r.w.cmd              = cmd;
    r.w.neuron_index     = IDX_W'(idx);
    r.w.weight_word      = word;
    r.w.activations      = act;
    r.typed              = (typed != 0);
    r.exp.hidden_bits    = hid;
    r.exp.out_bits       = ob;
    return r;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick           = $urandom_range(0, 19);
    w.neuron_index = IDX_W'($urandom);
    w.weight_word  = $urandom;
    w.activations  = ACT_W'($urandom);
    if (pick <= 10) begin
      w.cmd = CMD_INFER;
      case ($urandom_range(0, 9))
        0: w.activations = '0;
        1: w.activations = '1;
        default: ;
      endcase
    end else if (pick <= 14) begin
      w.cmd = CMD_LOAD_HIDDEN;
    end else if (pick <= 18) begin
      w.cmd = CMD_LOAD_OUTPUT;
      if ($urandom_range(0, 3) != 0) w.neuron_index = IDX_W'($urandom_range(0, OUT_COUNT - 1));
    end else begin
      w.cmd = CMD_UNUSED;
    end
    return w;
  endfunction

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t exp);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_data    <= w;
    row_typed  <= typed;
    row_expect <= exp;
    do @(posedge clk); while (in_stall);
  endtask

  // predict on accepted input words, check accepted output words
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_n && in_valid && !in_stall) begin
      if (in_data.cmd == CMD_INFER) begin
        inference_q.push_back(row_typed ? row_expect : infer_layers(in_data.activations));
      end else begin
        store_column(in_data);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      got = out_data;
      if (inference_q.size() == 0) begin
        $display("%0t: result word expected none, got hidden %h out %h",
                 $time, got.hidden_bits, got.out_bits);
        error_count++;
      end else begin
        want = inference_q.pop_front();
        if (got.hidden_bits !== want.hidden_bits) begin
          $display("%0t: hidden_bits expected %h got %h", $time, want.hidden_bits,
                   got.hidden_bits);
          error_count++;
        end
        if (got.out_bits !== want.out_bits) begin
          $display("%0t: out_bits expected %h got %h", $time, want.out_bits, got.out_bits);
          error_count++;
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    int n;
    int seen;
    out_stall  = 1'b0;
    out_steady = 1'b0;
    seen       = 0;
    forever begin
      n = out_steady ? 0 : $urandom_range(0, 18);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid && !out_stall));
      seen++;
      if (seen % 40 == 0) out_steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    stim_row_t rows [$];
    in_word_t  w;
    out_word_t none;
    int        sent;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    row_typed   = 1'b0;
    row_expect  = '0;
    error_count = 0;
    cycle_count = 0;
    in_steady   = 1'b0;
    none        = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // every column gets written before the first infer
    for (int i = 0; i < HIDDEN_COUNT; i++) begin
      w.cmd = CMD_LOAD_HIDDEN;
      w.neuron_index = IDX_W'(i);
      w.weight_word = 32'hFFFF_FFFF;
      w.activations = ACT_W'($urandom);
      send_word(w, 1'b0, none);
    end
    for (int i = 0; i < OUT_COUNT; i++) begin
      w.cmd = CMD_LOAD_OUTPUT;
      w.neuron_index = IDX_W'(i);
      w.weight_word = 32'hFFFF_FFFF;
      w.activations = ACT_W'($urandom);
      send_word(w, 1'b0, none);
    end

    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'hFFFF, 1, 32'hFFFF_FFFF, 8'hFF));
    rows.push_back(mk_row(CMD_INFER, 31, 32'hFFFF_FFFF, 16'h0000, 1, 32'h0, 8'h00));
    // zero sum counts as +1
    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'h00FF, 1, 32'hFFFF_FFFF, 8'hFF));
    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'h007F, 1, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_UNUSED, 31, 32'hFFFF_FFFF, 16'hFFFF, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_LOAD_OUTPUT, 31, 32'h0, 16'h0, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_LOAD_OUTPUT, 8, 32'h0, 16'h0, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'hFFFF, 1, 32'hFFFF_FFFF, 8'hFF));
    // upper weight bits of a hidden load are dropped
    rows.push_back(mk_row(CMD_LOAD_HIDDEN, 0, 32'hFFFF_0000, 16'h0, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_LOAD_HIDDEN, 31, 32'h0000_FFFF, 16'h0, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'hFFFF, 1, 32'hFFFF_FFFE, 8'hFF));
    rows.push_back(mk_row(CMD_LOAD_OUTPUT, 7, 32'h0, 16'h0, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'hFFFF, 1, 32'hFFFF_FFFE, 8'h7F));
    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'h0000, 1, 32'h0000_0001, 8'h80));
    rows.push_back(mk_row(CMD_LOAD_OUTPUT, 0, 32'hAAAA_AAAA, 16'h0, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_LOAD_OUTPUT, 1, 32'h0000_FFFF, 16'h0, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_LOAD_HIDDEN, 5, 32'h0000_5555, 16'h0, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'h5555, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'hAAAA, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'hFFFF, 0, 32'h0, 8'h00));
    rows.push_back(mk_row(CMD_INFER, 0, 32'h0, 16'h00FF, 0, 32'h0, 8'h00));

    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].exp);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      w = random_word();
      send_word(w, 1'b0, none);
      sent++;
      if (sent % 50 == 0) in_steady = ($urandom_range(0, 3) == 0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (inference_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bmi_pkg.sv
src/bmi_hidden_lane.sv
src/bmi_output_lane.sv
src/binary_mlp_inference_unit.sv
verif/tb_binary_mlp_inference_unit.sv
